@@ hdl/ffea_pkg.sv @@
// Shared types and constants of the first-fit extent allocator.
package ffea_pkg;

	localparam int MAX_EXTENTS_DEF = 256;
	localparam int SECTOR_BITS_DEF = 32;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_SPACE = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PLAN,
		S_CHECK,
		S_BUILD,
		S_DEL,
		S_READ,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] file_id;
		logic [31:0] sector_count;
		logic [31:0] sector;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [31:0] owner;
	} rsp_t;

endpackage

@@ hdl/ffea_cell.sv @@
// One cell of the elastic extent chain: holds one extent and passes it on when the next is empty.
module ffea_cell import ffea_pkg::*; #(
	parameter int EW = 96
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          prv_give,
	input  logic [EW-1:0] prv_data,
	input  logic          nxt_take,
	output logic          valid_q,
	output logic [EW-1:0] data_q,
	output logic          give
);

	assign give = valid_q & nxt_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (valid_q) begin
			valid_q <= !nxt_take;
		end else begin
			valid_q <= prv_give;
		end
	end

	// A cell only takes a new extent while it is empty.
	always_ff @(posedge clk) begin
		if (!valid_q && prv_give) begin
			data_q <= prv_data;
		end
	end

endmodule

@@ hdl/first_fit_extent_allocator.sv @@
// Top level of the first-fit extent allocator: request control and the chain of extent cells.
//
// The block keeps a table of extents, sorted by start sector, in a chain of cells.
// A request on the req channel (req_valid, req_stall, payload req) is a write of
// sector_count sectors for file_id, a delete of all extents of file_id, or a read
// of the owner of one sector, or a no-op. Exactly one response leaves on the rsp channel.
// A delete or a read circulates the whole table once through the chain: extents leave
// the last cell, pass a single head unit and, unless a delete drops them, re-enter at
// the first cell. A write of at least one sector circulates once to plan (count
// pieces, check room) and, unless refused, once more to rebuild; a zero-count write
// or a no-op goes straight to the response. A pass pops an extent into the head
// registers and pushes it back once the first cell is empty. With few free cells each
// freed cell has to travel back to the first cell before the extent can re-enter. A
// pass may also first wait for extents pushed back by the previous pass to reach the
// last cell.
// Only one request is in work at a time; req_stall is high from the cycle after
// acceptance until the response is loaded into the output register. If the
// receiver stalls, the response holds and the next one waits inside the block.
// Reset empties the table and the output register. A refused write leaves the
// table as it was and reports full or no space.
module first_fit_extent_allocator import ffea_pkg::*; #(
	parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
	parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int SB  = SECTOR_BITS;
	localparam int EW  = 32 + 2 * SB;
	localparam int AW  = (SB > 32 ? SB : 32) + 2;
	localparam int CNW = $clog2(MAX_EXTENTS + 1);
	localparam int PW  = CNW + 1;
	localparam logic [AW-1:0] LAST = AW'((AW'(1) << SB) - AW'(1));

	// Chain of cells.
	logic [MAX_EXTENTS-1:0] cell_v;
	logic [MAX_EXTENTS-1:0] cell_give;
	logic [EW-1:0]          cell_d [MAX_EXTENTS];
	logic                   push;
	logic [EW-1:0]          push_data;
	logic                   pop;

	for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
		logic          pg;
		logic [EW-1:0] pd;
		logic          nt;
		if (i == 0) begin : g_first
			assign pg = push;
			assign pd = push_data;
		end else begin : g_mid
			assign pg = cell_give[i-1];
			assign pd = cell_d[i-1];
		end
		if (i == MAX_EXTENTS - 1) begin : g_last
			assign nt = pop;
		end else begin : g_inner
			assign nt = !cell_v[i+1];
		end
		ffea_cell #(.EW(EW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.prv_give (pg),
			.prv_data (pd),
			.nxt_take (nt),
			.valid_q  (cell_v[i]),
			.data_q   (cell_d[i]),
			.give     (cell_give[i])
		);
	end

	// Control and head registers.
	state_t         state_q, state_d;
	logic [CNW-1:0] count_q, ncount_q, popped_q;
	logic [PW-1:0]  pieces_q;
	logic [31:0]    fid_q, owner_q;
	logic [AW-1:0]  nf_q, rem_q, wcount_q, sec_q;
	logic           hold_v_q;
	logic [31:0]    h_own_q;
	logic [SB-1:0]  h_st_q, h_en_q;
	logic [1:0]     status_q;
	logic           found_q;
	logic           rsp_valid_q;
	rsp_t           rsp_q;

	// Gap in front of the held extent and the piece that would fill it.
	logic [AW-1:0] st_a, en_a, gap, take;
	logic          gap_pos, piece, step_piece, drop, consume, tail, pass_end;
	logic          in_pass, accept, fin_go, full, space;
	logic [PW-1:0] pieces_tot;
	logic [AW-1:0] tail_end;

	assign st_a    = AW'(h_st_q);
	assign en_a    = AW'(h_en_q);
	assign gap_pos = st_a > nf_q;
	assign gap     = st_a - nf_q;
	assign take    = (rem_q < gap) ? rem_q : gap;
	assign piece   = hold_v_q && gap_pos && (rem_q != '0)
		&& (state_q == S_PLAN || state_q == S_BUILD);
	assign step_piece = piece && (state_q == S_PLAN || !cell_v[0]);
	assign drop    = (state_q == S_DEL) && (h_own_q == fid_q);
	assign consume = hold_v_q && !piece && (!cell_v[0] || drop);
	assign tail    = (state_q == S_BUILD) && !hold_v_q && (popped_q == count_q)
		&& (rem_q != '0);
	assign in_pass = (state_q == S_PLAN) || (state_q == S_BUILD)
		|| (state_q == S_DEL) || (state_q == S_READ);
	assign pop     = in_pass && cell_v[MAX_EXTENTS-1] && !hold_v_q && (popped_q != count_q);
	assign pass_end = in_pass && !hold_v_q && (popped_q == count_q)
		&& !(state_q == S_BUILD && rem_q != '0);
	assign tail_end   = nf_q + rem_q - AW'(1);
	assign pieces_tot = pieces_q + PW'(rem_q != '0);
	assign full  = pieces_tot > PW'(MAX_EXTENTS - int'(count_q));
	assign space = (rem_q != '0) && (tail_end > LAST);
	assign accept = (state_q == S_IDLE) && req_valid;
	assign fin_go = (state_q == S_FIN) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		push      = 1'b0;
		push_data = {h_own_q, h_st_q, h_en_q};
		if (state_q == S_BUILD && step_piece) begin
			push      = 1'b1;
			push_data = {fid_q, SB'(nf_q), SB'(nf_q + take - AW'(1))};
		end else if (tail && !cell_v[0]) begin
			push      = 1'b1;
			push_data = {fid_q, SB'(nf_q), SB'(tail_end)};
		end else if (consume && !drop) begin
			push = 1'b1;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					unique case (req.operation)
						OP_WRITE:  state_d = (req.sector_count == '0) ? S_FIN : S_PLAN;
						OP_DELETE: state_d = S_DEL;
						OP_READ:   state_d = S_READ;
						default:   state_d = S_FIN;
					endcase
				end
			end
			S_PLAN: begin
				if (pass_end) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: state_d = (full || space) ? S_FIN : S_BUILD;
			S_BUILD, S_DEL, S_READ: begin
				if (pass_end) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (fin_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		req_stall = (state_q != S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ncount_q    <= '0;
			popped_q    <= '0;
			hold_v_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept || state_q == S_CHECK) begin
				popped_q <= '0;
				ncount_q <= '0;
			end else begin
				if (pop) begin
					popped_q <= popped_q + CNW'(1);
				end
				if (push) begin
					ncount_q <= ncount_q + CNW'(1);
				end
			end
			if (pop) begin
				hold_v_q <= 1'b1;
			end else if (consume) begin
				hold_v_q <= 1'b0;
			end
			if (pass_end && (state_q == S_BUILD || state_q == S_DEL)) begin
				count_q <= ncount_q;
			end
			if (fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Head datapath.
	always_ff @(posedge clk) begin
		if (pop) begin
			{h_own_q, h_st_q, h_en_q} <= cell_d[MAX_EXTENTS-1];
		end
		if (accept) begin
			fid_q    <= req.file_id;
			wcount_q <= AW'(req.sector_count);
			rem_q    <= AW'(req.sector_count);
			sec_q    <= AW'(req.sector);
			nf_q     <= '0;
			pieces_q <= '0;
			status_q <= ST_DONE;
			found_q  <= 1'b0;
			owner_q  <= '0;
		end else if (state_q == S_CHECK) begin
			nf_q  <= '0;
			rem_q <= wcount_q;
			if (full) begin
				status_q <= ST_FULL;
			end else if (space) begin
				status_q <= ST_SPACE;
			end
		end else if (step_piece) begin
			if (state_q == S_PLAN) begin
				pieces_q <= pieces_q + PW'(1);
			end
			rem_q <= rem_q - take;
			nf_q  <= nf_q + take;
		end else if (tail && !cell_v[0]) begin
			rem_q <= '0;
		end else if (consume) begin
			nf_q <= en_a + AW'(1);
			if (state_q == S_READ && !found_q && sec_q >= st_a && sec_q <= en_a) begin
				found_q <= 1'b1;
				owner_q <= h_own_q;
			end
		end
		if (fin_go) begin
			rsp_q <= '{status: status_q, found: found_q, owner: owner_q};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The chain holds exactly the stored extents whenever the block is idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ($countones(cell_v) == int'(count_q)))
		else $error("extent chain occupancy differs from the extent count");

	// A response appears only when the request has finished.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == S_FIN))
		else $error("response raised outside the finish state");

	// A pass never takes more extents out of the chain than it holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (popped_q < count_q))
		else $error("extent popped beyond the stored count");

	// A refused write never touches the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && (full || space)) |=> (count_q == $past(count_q)))
		else $error("refused write changed the table");

endmodule

@@ tb/first_fit_extent_allocator_tb.sv @@
// Testbench of the first-fit extent allocator: directed table, random requests, checked by a model.
`timescale 1ns / 1ps

module first_fit_extent_allocator_tb import ffea_pkg::*;;

	localparam int NEXT = 256;
	localparam longint LAST_SEC = 64'hFFFF_FFFF;
	localparam int N_RANDOM = 1015;
	localparam longint CYCLE_LIMIT = 64'd40_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b1;
	rsp_t rsp;

	first_fit_extent_allocator i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the extent table, kept sorted by start sector.
	logic [31:0] tbl_owner[NEXT];
	longint tbl_start[NEXT];
	longint tbl_end[NEXT];
	int tbl_count;

	rsp_t pending_rsp[$];
	int errors = 0;
	longint cycles = 0;
	bit hold_long = 1'b0;
	bit stim_done = 1'b0;

	// The directed table. A row with check set carries a response known by inspection.
	typedef struct {
		req_t r;
		bit check;
		rsp_t want;
	} row_t;

	row_t rows[$];

	function automatic void add_row(req_t r, bit check, rsp_t want);
		row_t w;
		w.r = r; w.check = check; w.want = want;
		rows = {rows, w};
	endfunction

	function automatic void expect_rsp(rsp_t e);
		pending_rsp = {pending_rsp, e};
	endfunction

	function automatic rsp_t allocate(req_t r);
		rsp_t o;
		longint nf, rem, gap, take, tail;
		int pieces, n;
		logic [31:0] no[NEXT];
		longint ns[NEXT], ne[NEXT];
		o = '0;
		case (r.operation)
			OP_WRITE: begin
				if (r.sector_count != 0) begin
					nf = 0; rem = r.sector_count; pieces = 0; tail = 0;
					for (int i = 0; i < tbl_count; i++) begin
						gap = (tbl_start[i] > nf) ? tbl_start[i] - nf : 0;
						if (gap > 0 && rem > 0) begin
							pieces++;
							rem -= (rem < gap) ? rem : gap;
						end
						nf = tbl_end[i] + 1;
					end
					if (rem > 0) begin
						pieces++;
						tail = nf + rem - 1;
					end
					if (pieces > NEXT - tbl_count) o.status = ST_FULL;
					else if (rem > 0 && tail > LAST_SEC) o.status = ST_SPACE;
					else begin
						nf = 0; rem = r.sector_count; n = 0;
						for (int i = 0; i < tbl_count; i++) begin
							gap = (tbl_start[i] > nf) ? tbl_start[i] - nf : 0;
							if (gap > 0 && rem > 0) begin
								take = (rem < gap) ? rem : gap;
								no[n] = r.file_id; ns[n] = nf; ne[n] = nf + take - 1;
								n++;
								rem -= take;
							end
							no[n] = tbl_owner[i]; ns[n] = tbl_start[i]; ne[n] = tbl_end[i];
							n++;
							nf = tbl_end[i] + 1;
						end
						if (rem > 0) begin
							no[n] = r.file_id; ns[n] = nf; ne[n] = nf + rem - 1;
							n++;
						end
						for (int i = 0; i < n; i++) begin
							tbl_owner[i] = no[i]; tbl_start[i] = ns[i]; tbl_end[i] = ne[i];
						end
						tbl_count = n;
					end
				end
			end
			OP_DELETE: begin
				n = 0;
				for (int i = 0; i < tbl_count; i++)
					if (tbl_owner[i] != r.file_id) begin
						tbl_owner[n] = tbl_owner[i]; tbl_start[n] = tbl_start[i];
						tbl_end[n] = tbl_end[i];
						n++;
					end
				tbl_count = n;
			end
			OP_READ: begin
				for (int i = 0; i < tbl_count; i++)
					if (tbl_start[i] <= r.sector && r.sector <= tbl_end[i]) begin
						o.found = 1'b1;
						o.owner = tbl_owner[i];
						break;
					end
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
		errors++;
	endtask

	// Short gaps usually, a long one now and then.
	function automatic int gap_len();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 400);
		return $urandom_range(0, 4);
	endfunction

	task automatic send(req_t r);
		rsp_t e;
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		e = allocate(r);
		expect_rsp(e);
	endtask

	task automatic send_checked(req_t r, rsp_t want);
		rsp_t e;
		e = allocate(r);
		if (e !== want) report_mismatch("directed row", {29'd0, e.status, e.found}, {29'd0, want.status, want.found});
		expect_rsp(want);
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	function automatic req_t mk(logic [1:0] op, logic [31:0] f, logic [31:0] c, logic [31:0] s);
		req_t r;
		r.operation = op; r.file_id = f; r.sector_count = c; r.sector = s;
		return r;
	endfunction

	function automatic rsp_t rs(logic [1:0] st, logic fd, logic [31:0] ow);
		rsp_t o;
		o.status = st; o.found = fd; o.owner = ow;
		return o;
	endfunction

	// Sender: directed table first, then a fill phase, then random requests.
	initial begin : sender
		req_t r;
		int g, pick;
		logic [31:0] fids[4];
		add_row(mk(OP_READ, 0, 0, 0), 1, rs(ST_DONE, 0, 0));
		add_row(mk(OP_WRITE, 32'hFFFF_FFFF, 0, 5), 1, rs(ST_DONE, 0, 0));
		add_row(mk(OP_DELETE, 7, 0, 0), 1, rs(ST_DONE, 0, 0));
		add_row(mk(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1,
			rs(ST_DONE, 0, 0));
		add_row(mk(OP_WRITE, 32'hA5A5_5A5A, 10, 0), 1, rs(ST_DONE, 0, 0));
		add_row(mk(OP_READ, 0, 0, 0), 1, rs(ST_DONE, 1, 32'hA5A5_5A5A));
		add_row(mk(OP_READ, 0, 0, 9), 1, rs(ST_DONE, 1, 32'hA5A5_5A5A));
		add_row(mk(OP_READ, 0, 0, 10), 1, rs(ST_DONE, 0, 0));
		add_row(mk(OP_WRITE, 2, 32'hFFFF_FFFF, 0), 1, rs(ST_SPACE, 0, 0));
		add_row(mk(OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFF6, 0), 1, rs(ST_DONE, 0, 0));
		add_row(mk(OP_READ, 0, 0, 32'hFFFF_FFFF), 1, rs(ST_DONE, 1, 32'hFFFF_FFFF));
		add_row(mk(OP_WRITE, 3, 1, 0), 1, rs(ST_SPACE, 0, 0));
		add_row(mk(OP_DELETE, 32'hA5A5_5A5A, 0, 0), 1, rs(ST_DONE, 0, 0));
		add_row(mk(OP_WRITE, 4, 3, 0), 0, '0);
		add_row(mk(OP_WRITE, 5, 20, 0), 0, '0);
		add_row(mk(OP_READ, 0, 0, 9), 0, '0);
		add_row(mk(OP_DELETE, 32'hFFFF_FFFF, 0, 0), 1, rs(ST_DONE, 0, 0));
		add_row(mk(OP_READ, 0, 0, 5), 0, '0);
		add_row(mk(OP_DELETE, 4, 0, 0), 0, '0);
		add_row(mk(OP_DELETE, 5, 0, 0), 0, '0);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			if (rows[i].check) send_checked(rows[i].r, rows[i].want);
			else send(rows[i].r);
			g = gap_len();
			if (g > 0) begin
				req_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
		// Fill the table with one-sector extents and then punch holes, so that full
		// refusals and gap filling both occur; the receiver starts its one long hold-off here.
		hold_long = 1'b1;
		for (int i = 0; i < 258; i++) send(mk(OP_WRITE, i % 2 ? 32'd20 : 32'd21, 1, 0));
		send(mk(OP_DELETE, 20, 0, 0));
		send(mk(OP_WRITE, 22, 300, 0));
		send(mk(OP_WRITE, 23, 1000, 0));
		send(mk(OP_READ, 0, 0, 1));
		send(mk(OP_DELETE, 21, 0, 0));
		send(mk(OP_DELETE, 22, 0, 0));
		send(mk(OP_DELETE, 23, 0, 0));
		for (int i = 0; i < 4; i++) fids[i] = $urandom();
		for (int i = 0; i < N_RANDOM; i++) begin
			pick = $urandom_range(0, 99);
			r.file_id = fids[$urandom_range(0, 3)];
			r.sector_count = $urandom_range(0, 40);
			r.sector = $urandom_range(0, 400);
			if (pick < 40) r.operation = OP_WRITE;
			else if (pick < 55) r.operation = OP_DELETE;
			else if (pick < 93) r.operation = OP_READ;
			else if (pick < 96) begin
				r.operation = OP_NOP;
				r.file_id = $urandom(); r.sector_count = $urandom(); r.sector = $urandom();
			end else begin
				r.operation = pick[0] ? OP_WRITE : OP_READ;
				r.file_id = $urandom(); r.sector_count = $urandom(); r.sector = $urandom();
			end
			if ($urandom_range(0, 49) == 0) fids[$urandom_range(0, 3)] = $urandom();
			send(r);
			g = gap_len();
			if (g > 0) begin
				req_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
		req_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver: random stall, with one long hold-off set off by the sender's fill phase.
	initial begin : receiver
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				hold_long = 1'b0;
				rsp_stall <= 1'b1;
				repeat (3000) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			g = gap_len();
			if (g > 0) begin
				rsp_stall <= 1'b1;
				repeat (g) @(posedge clk);
			end
		end
	end

	// Compare every accepted response with the oldest expectation.
	always @(posedge clk) begin
		rsp_t e;
		cycles <= cycles + 1;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected response", rsp.owner, 32'd0);
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.status !== e.status)
					report_mismatch("status", 32'(rsp.status), 32'(e.status));
				if (rsp.found !== e.found)
					report_mismatch("found", 32'(rsp.found), 32'(e.found));
				if (rsp.owner !== e.owner) report_mismatch("owner", rsp.owner, e.owner);
			end
		end
	end

	initial begin : finisher
		wait (stim_done);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0) $display("** first_fit_extent_allocator: PASSED **");
		else $display("** first_fit_extent_allocator: FAILED **");
		$finish;
	end

	initial begin : watchdog
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycles);
		$display("** first_fit_extent_allocator: FAILED **");
		$finish;
	end

endmodule
